>>> hw/rtl/gsfp_pkg.sv
// Shared types and constants for the gas sensor frame parser.
package gsfp_pkg;

  localparam logic [7:0] SOF_BYTE     = 8'hFF;
  localparam logic [7:0] CMD_RESET    = 8'h86;
  localparam logic [3:0] POS_HUNT     = 4'd0;
  localparam logic [3:0] POS_CMD      = 4'd1;
  localparam logic [3:0] POS_FIRST_PL = 4'd2;
  localparam logic [3:0] POS_CSUM     = 4'd10;
  localparam int unsigned PL_BYTES    = 8;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_ABANDON = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_GOOD = 2'd0,
    STAT_CSUM = 2'd1,
    STAT_CMD  = 2'd2
  } stat_t;

  typedef struct packed {
    stat_t       status;
    logic [15:0] co_reading;
    logic [15:0] h2s_reading;
    logic [15:0] o2_tenths;
    logic [15:0] ch4_reading;
    logic [7:0]  received_sum;
    logic [7:0]  computed_sum;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } parse_out_t;

endpackage

>>> hw/rtl/gsfp_parser.sv
// Frame position tracking, running checksum, payload capture and result build.
module gsfp_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  gsfp_pkg::op_t          op,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             expected_command,
  output gsfp_pkg::parse_out_t   po
);

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] pay_r [gsfp_pkg::PL_BYTES];
  logic       hunting;
  logic       in_payload;
  logic [7:0] computed;

  assign hunting    = (pos_r == gsfp_pkg::POS_HUNT) || (pos_r > gsfp_pkg::POS_CSUM);
  assign in_payload = !hunting && (pos_r >= gsfp_pkg::POS_FIRST_PL) &&
                      (pos_r < gsfp_pkg::POS_CSUM);
  assign computed   = ~sum_r + 8'd1;

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    po      = '0;
    if (op == gsfp_pkg::OP_ABANDON) begin
      pos_nxt = gsfp_pkg::POS_HUNT;
      sum_nxt = 8'd0;
    end else if (hunting) begin
      pos_nxt = (rx_byte == gsfp_pkg::SOF_BYTE) ? gsfp_pkg::POS_CMD : gsfp_pkg::POS_HUNT;
      sum_nxt = 8'd0;
    end else if (pos_r == gsfp_pkg::POS_CMD) begin
      if (rx_byte != expected_command) begin
        po.emit       = 1'b1;
        po.res.status = gsfp_pkg::STAT_CMD;
        pos_nxt       = gsfp_pkg::POS_HUNT;
        sum_nxt       = 8'd0;
      end else begin
        pos_nxt = gsfp_pkg::POS_FIRST_PL;
        sum_nxt = rx_byte;
      end
    end else if (in_payload) begin
      pos_nxt = pos_r + 4'd1;
      sum_nxt = sum_r + rx_byte;
    end else begin
      po.emit             = 1'b1;
      po.res.status       = (computed == rx_byte) ? gsfp_pkg::STAT_GOOD : gsfp_pkg::STAT_CSUM;
      po.res.co_reading   = {pay_r[7], pay_r[6]};
      po.res.h2s_reading  = {pay_r[5], pay_r[4]};
      po.res.o2_tenths    = {pay_r[3], pay_r[2]};
      po.res.ch4_reading  = {pay_r[1], pay_r[0]};
      po.res.received_sum = rx_byte;
      po.res.computed_sum = computed;
      pos_nxt             = gsfp_pkg::POS_HUNT;
      sum_nxt             = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= gsfp_pkg::POS_HUNT;
      sum_r <= 8'd0;
    end else if (step_en) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // payload shift line: oldest byte ends at index 7
  always_ff @(posedge clk) begin
    if (step_en && (op == gsfp_pkg::OP_BYTE) && in_payload) begin
      pay_r[0] <= rx_byte;
      for (int i = 1; i < gsfp_pkg::PL_BYTES; i++) begin
        pay_r[i] <= pay_r[i-1];
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= gsfp_pkg::POS_CSUM)
    else $error("frame position out of range");

  a_emit_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && po.emit |=> pos_r == gsfp_pkg::POS_HUNT && sum_r == 8'd0)
    else $error("parser did not return to hunting after a result");

  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= gsfp_pkg::POS_CMD |-> sum_r == 8'd0)
    else $error("running sum not clear before command byte");

endmodule

>>> hw/rtl/gsfp_out_reg.sv
// Result holding register on the output channel.
module gsfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  gsfp_pkg::result_t din,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output gsfp_pkg::result_t dout
);

  logic              vld_r;
  gsfp_pkg::result_t res_r;

  assign free      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign dout      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= din;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !out_ready |-> !load)
    else $error("pending result overwritten");

endmodule

>>> hw/rtl/gas_sensor_frame_parser_unit.sv
// Gas sensor reply frame parser: top level with request register and glue.
// Takes one received byte (or an abandon request) per cycle while in_ready is
// high and gives one result per 11-byte frame, or per frame rejected at its
// command byte. A request is registered when taken and is processed from that
// register once the parser may step; a result is then loaded into the output
// register when its checksum or bad command byte is processed. in_ready drops
// only while a result-bearing request waits behind an unread result in the
// output register; bytes that give no result keep flowing meanwhile.
// cfg_wr_data sets the expected command byte (reset 0x86).
module gas_sensor_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_co_reading,
  output logic [15:0] out_h2s_reading,
  output logic [15:0] out_o2_tenths,
  output logic [15:0] out_ch4_reading,
  output logic [7:0]  out_received_sum,
  output logic [7:0]  out_computed_sum
);

  logic                 req_vld_r;
  gsfp_pkg::op_t        req_op_r;
  logic [7:0]           req_byte_r;
  logic [7:0]           cmd_r;
  logic                 proc;
  logic                 slot_free;
  gsfp_pkg::parse_out_t po;
  gsfp_pkg::result_t    res;

  assign proc     = req_vld_r && (!po.emit || slot_free);
  assign in_ready = !req_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= gsfp_pkg::CMD_RESET;
    end else if (cfg_wr_en) begin
      cmd_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op_r   <= gsfp_pkg::op_t'(in_opcode);
      req_byte_r <= in_rx_byte;
    end
  end

  gsfp_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (proc),
    .op               (req_op_r),
    .rx_byte          (req_byte_r),
    .expected_command (cmd_r),
    .po               (po)
  );

  gsfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc && po.emit),
    .din       (po.res),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res)
  );

  assign out_status       = res.status;
  assign out_co_reading   = res.co_reading;
  assign out_h2s_reading  = res.h2s_reading;
  assign out_o2_tenths    = res.o2_tenths;
  assign out_ch4_reading  = res.ch4_reading;
  assign out_received_sum = res.received_sum;
  assign out_computed_sum = res.computed_sum;

endmodule

>>> tb/tb_gas_sensor_frame_parser_unit.sv
// Self-checking testbench for the gas sensor frame parser: directed frames, then random traffic.
module tb_gas_sensor_frame_parser_unit;

  localparam int PHASES       = 7;
  localparam int PER_PHASE    = 250;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    gsfp_pkg::op_t     op;
    logic [7:0]        b;
    logic              lit_on;
    gsfp_pkg::result_t lit;
  } stim_row_t;

  localparam gsfp_pkg::result_t NO_LIT    = '0;
  localparam gsfp_pkg::result_t LIT_CMD   = {gsfp_pkg::STAT_CMD, 80'h0};
  localparam gsfp_pkg::result_t LIT_ONES  =
    {gsfp_pkg::STAT_GOOD, 64'hFFFF_FFFF_FFFF_FFFF, 8'h82, 8'h82};
  localparam gsfp_pkg::result_t LIT_ZEROS = {gsfp_pkg::STAT_CSUM, 64'h0, 8'h00, 8'h7A};

  // reset command 0x86 throughout
  localparam stim_row_t SCRIPT [26] = '{
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b1, LIT_CMD},   // rejected byte must not restart
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h86, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h82, 1'b1, LIT_ONES},
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_ABANDON, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'hFF, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h86, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT}, {gsfp_pkg::OP_BYTE, 8'h00, 1'b0, NO_LIT},
    {gsfp_pkg::OP_BYTE, 8'h00, 1'b1, LIT_ZEROS}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_co_reading;
  logic [15:0] out_h2s_reading;
  logic [15:0] out_o2_tenths;
  logic [15:0] out_ch4_reading;
  logic [7:0]  out_received_sum;
  logic [7:0]  out_computed_sum;

  gas_sensor_frame_parser_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_co_reading   (out_co_reading),
    .out_h2s_reading  (out_h2s_reading),
    .out_o2_tenths    (out_o2_tenths),
    .out_ch4_reading  (out_ch4_reading),
    .out_received_sum (out_received_sum),
    .out_computed_sum (out_computed_sum)
  );

  // parser mirror
  logic [3:0] pos_q;
  logic [7:0] sum_q;
  logic [7:0] pl_q [gsfp_pkg::PL_BYTES];
  logic [7:0] cmd_q;

  gsfp_pkg::result_t frames_due [$];
  gsfp_pkg::result_t want_r;
  bit      in_calm;
  bit      out_calm;
  int      n_fail;
  int      n_sent;
  int      n_checked;
  int      n_good;
  int      n_csum;
  int      n_cmd;
  int      n_cfg;
  int      cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic parse_byte(input gsfp_pkg::op_t op, input logic [7:0] b,
                            output bit emit, output gsfp_pkg::result_t r);
    r = '0;
    emit = 1'b0;
    if (op == gsfp_pkg::OP_ABANDON) begin
      pos_q = gsfp_pkg::POS_HUNT;
      sum_q = 8'h00;
    end else if (pos_q == gsfp_pkg::POS_HUNT || pos_q > gsfp_pkg::POS_CSUM) begin
      pos_q = (b == gsfp_pkg::SOF_BYTE) ? gsfp_pkg::POS_CMD : gsfp_pkg::POS_HUNT;
      sum_q = 8'h00;
    end else if (pos_q == gsfp_pkg::POS_CMD) begin
      if (b != cmd_q) begin
        emit = 1'b1;
        r.status = gsfp_pkg::STAT_CMD;
        pos_q = gsfp_pkg::POS_HUNT;
        sum_q = 8'h00;
      end else begin
        sum_q = b;
        pos_q = gsfp_pkg::POS_FIRST_PL;
      end
    end else if (pos_q < gsfp_pkg::POS_CSUM) begin
      pl_q[3'(pos_q - gsfp_pkg::POS_FIRST_PL)] = b;
      sum_q = sum_q + b;
      pos_q = pos_q + 4'd1;
    end else begin
      emit = 1'b1;
      r.computed_sum = -sum_q;
      r.status = (r.computed_sum == b) ? gsfp_pkg::STAT_GOOD : gsfp_pkg::STAT_CSUM;
      r.co_reading = {pl_q[0], pl_q[1]};
      r.h2s_reading = {pl_q[2], pl_q[3]};
      r.o2_tenths = {pl_q[4], pl_q[5]};
      r.ch4_reading = {pl_q[6], pl_q[7]};
      r.received_sum = b;
      pos_q = gsfp_pkg::POS_HUNT;
      sum_q = 8'h00;
    end
  endtask

  // called and returns at a falling edge
  task automatic send_request(input gsfp_pkg::op_t op, input logic [7:0] b,
                              input bit lit_on, input gsfp_pkg::result_t lit);
    int gap;
    bit emit;
    gsfp_pkg::result_t r;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    parse_byte(op, b, emit, r);
    if (lit_on) begin
      frames_due.push_back(lit);
    end else if (emit) begin
      frames_due.push_back(r);
    end
    n_sent++;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_burst();
    logic [7:0] fb [11];
    logic [7:0] s;
    int cut;
    case ($urandom_range(0, 9))
      0: send_request(gsfp_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_LIT);
      1: send_request(gsfp_pkg::OP_ABANDON, 8'($urandom_range(0, 255)), 1'b0, NO_LIT);
      default: begin
        fb[0] = gsfp_pkg::SOF_BYTE;
        fb[1] = ($urandom_range(0, 7) == 0) ? cmd_q ^ 8'($urandom_range(1, 255)) : cmd_q;
        s = fb[1];
        for (int k = 2; k < 10; k++) begin
          fb[k] = pick_byte();
          s = s + fb[k];
        end
        fb[10] = ($urandom_range(0, 5) == 0) ? pick_byte() : -s;
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 10) : 11;
        for (int k = 0; k < 11; k++) begin
          if (k == cut) begin
            send_request(gsfp_pkg::OP_ABANDON, 8'($urandom_range(0, 255)), 1'b0, NO_LIT);
            break;
          end
          send_request(gsfp_pkg::OP_BYTE, fb[k], 1'b0, NO_LIT);
        end
      end
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cmd(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cmd_q = v;
    n_cfg++;
  endtask

  task automatic chk(input string name, input logic [15:0] exp_v, input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        $error("result with none pending, status %0d", out_status);
        n_fail++;
      end else begin
        want_r = frames_due.pop_front();
        chk("status", 16'(want_r.status), 16'(out_status));
        chk("co_reading", want_r.co_reading, out_co_reading);
        chk("h2s_reading", want_r.h2s_reading, out_h2s_reading);
        chk("o2_tenths", want_r.o2_tenths, out_o2_tenths);
        chk("ch4_reading", want_r.ch4_reading, out_ch4_reading);
        chk("received_sum", 16'(want_r.received_sum), 16'(out_received_sum));
        chk("computed_sum", 16'(want_r.computed_sum), 16'(out_computed_sum));
        n_checked++;
        case (want_r.status)
          gsfp_pkg::STAT_GOOD: n_good++;
          gsfp_pkg::STAT_CSUM: n_csum++;
          default:             n_cmd++;
        endcase
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
      @(negedge clk);
    end
  end

  initial begin
    logic [7:0] setting;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    in_valid = 1'b0;
    in_opcode = gsfp_pkg::OP_BYTE;
    in_rx_byte = 8'h00;
    pos_q = gsfp_pkg::POS_HUNT;
    sum_q = 8'h00;
    cmd_q = gsfp_pkg::CMD_RESET;
    for (int k = 0; k < gsfp_pkg::PL_BYTES; k++) pl_q[k] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (SCRIPT[i]) send_request(SCRIPT[i].op, SCRIPT[i].b, SCRIPT[i].lit_on, SCRIPT[i].lit);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = 8'h00;
        1: setting = 8'hFF;
        3: setting = gsfp_pkg::CMD_RESET;
        default: setting = 8'($urandom_range(0, 255));
      endcase
      settle();
      write_cmd(setting);
      n_sent = 0;
      while (n_sent < PER_PHASE) send_random_burst();
    end
    settle();

    $display("Covered %0d command settings; %0d results checked", n_cfg + 1, n_checked);
    $display("Frames good %0d, checksum errors %0d, command errors %0d", n_good, n_csum, n_cmd);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
